/* sv/pan_tilt_forward_kinematics_assert.svh */
// Assertion macros for the pan-tilt kinematics block.
// Included by the top level only.
`ifndef PAN_TILT_FORWARD_KINEMATICS_ASSERT_SVH
`define PAN_TILT_FORWARD_KINEMATICS_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PTFK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTFK_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/ptfk_pkg.sv */
// Package for pan-tilt kinematics: widths, CORDIC constants, helper types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptfk_pkg;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int WORK_FRAC  = 30;
  localparam int WORK_BITS  = 34;
  localparam int OFS_BITS   = 16;
  localparam int OUT_BITS   = 16;
  localparam int TR_BITS    = 19;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HORIZONTAL = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTICAL   = 1'b1;
  localparam logic [OFS_BITS-1:0] HZ_RESET = 16'd5014;
  localparam logic [OFS_BITS-1:0] V_RESET  = 16'd4456;
  localparam logic signed [WORK_BITS-1:0] GAIN_Q30    = 34'sh026DD3B6A;
  localparam logic signed [WORK_BITS-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WORK_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam longint TR_LIMIT = 131072;

  typedef logic signed [WORK_BITS-1:0] work_t;

  function automatic work_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sh03243F6A8;  1: atan_q30 = 34'sh01DAC6705;
      2: atan_q30 = 34'sh00FADBAFC;  3: atan_q30 = 34'sh007F56EA6;
      4: atan_q30 = 34'sh003FEAB76;  5: atan_q30 = 34'sh001FFD55B;
      6: atan_q30 = 34'sh000FFFAAA;  7: atan_q30 = 34'sh0007FFF55;
      8: atan_q30 = 34'sh0003FFFEA;  9: atan_q30 = 34'sh0001FFFFD;
      10: atan_q30 = 34'sh0000FFFFF; 11: atan_q30 = 34'sh00007FFFF;
      12: atan_q30 = 34'sh00003FFFF; 13: atan_q30 = 34'sh00001FFFF;
      14: atan_q30 = 34'sh00000FFFF; 15: atan_q30 = 34'sh000007FFF;
      16: atan_q30 = 34'sh000003FFF; 17: atan_q30 = 34'sh000001FFF;
      18: atan_q30 = 34'sh000000FFF; 19: atan_q30 = 34'sh0000007FF;
      20: atan_q30 = 34'sh0000003FF; 21: atan_q30 = 34'sh0000001FF;
      22: atan_q30 = 34'sh0000000FF; 23: atan_q30 = 34'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* sv/ptfk_if.sv */
// Valid/ready channel interface carrying one payload word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ptfk_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/ptfk_cordic.sv */
// Pipelined CORDIC lane: angle in, rounded sine and cosine out.
// Depends on ptfk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptfk_cordic #(
  parameter int ANGLE_BITS     = ptfk_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = ptfk_pkg::TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = ptfk_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [ANGLE_BITS-1:0]  angle,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_o
);
  localparam int W  = ptfk_pkg::WORK_BITS;
  localparam int NS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int SH = ptfk_pkg::WORK_FRAC - TRIG_FRAC_BITS;
  localparam int TW = TRIG_FRAC_BITS + 2;

  ptfk_pkg::work_t x [NS+1];
  ptfk_pkg::work_t y [NS+1];
  ptfk_pkg::work_t z [NS+1];
  logic            neg [NS+1];

  ptfk_pkg::work_t a0;
  always_comb begin
    a0 = ptfk_pkg::work_t'(angle) <<< (ptfk_pkg::WORK_FRAC - (ANGLE_BITS - 3));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= ptfk_pkg::GAIN_Q30;
      y[0] <= '0;
      if (a0 > ptfk_pkg::HALF_PI_Q30) begin
        z[0] <= a0 - ptfk_pkg::PI_Q30; neg[0] <= 1'b1;
      end else if (a0 < -ptfk_pkg::HALF_PI_Q30) begin
        z[0] <= a0 + ptfk_pkg::PI_Q30; neg[0] <= 1'b1;
      end else begin
        z[0] <= a0; neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!z[i][W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ptfk_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ptfk_pkg::atan_q30(i);
        end
      end
    end
  end

  function automatic logic signed [TW-1:0] to_trig(input ptfk_pkg::work_t v);
    ptfk_pkg::work_t r;
    r = (v + (ptfk_pkg::work_t'(1) <<< (SH - 1))) >>> SH;
    if (r > (ptfk_pkg::work_t'(1) <<< TRIG_FRAC_BITS))
      r = ptfk_pkg::work_t'(1) <<< TRIG_FRAC_BITS;
    else if (r < -(ptfk_pkg::work_t'(1) <<< TRIG_FRAC_BITS))
      r = -(ptfk_pkg::work_t'(1) <<< TRIG_FRAC_BITS);
    return r[TW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= to_trig(neg[NS] ? -y[NS] : y[NS]);
      cos_o <= to_trig(neg[NS] ? -x[NS] : x[NS]);
    end
  end
endmodule
`default_nettype wire

/* sv/ptfk_merge.sv */
// Merge stage: rotation products, then translations, two registered steps.
// Depends on ptfk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptfk_merge #(
  parameter int TRIG_FRAC_BITS = ptfk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]  sp,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]  cp,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]  st,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]  ct,
  input  wire logic [ptfk_pkg::OFS_BITS-1:0]     hz,
  input  wire logic [ptfk_pkg::OFS_BITS-1:0]     vo,
  output logic signed [TRIG_FRAC_BITS+1:0]       m [8],
  output logic signed [ptfk_pkg::TR_BITS-1:0]    t [3]
);
  localparam int TW = TRIG_FRAC_BITS + 2;
  typedef logic signed [63:0] wide_t;
  logic signed [TW-1:0] r [8];

  function automatic logic signed [TW-1:0] mul_trig(input logic signed [TW-1:0] a,
                                                      input logic signed [TW-1:0] b);
    wide_t p;
    p = (wide_t'(a) * wide_t'(b) + (wide_t'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (p > (wide_t'(1) <<< TRIG_FRAC_BITS)) p = wide_t'(1) <<< TRIG_FRAC_BITS;
    else if (p < -(wide_t'(1) <<< TRIG_FRAC_BITS)) p = -(wide_t'(1) <<< TRIG_FRAC_BITS);
    return p[TW-1:0];
  endfunction

  function automatic logic signed [ptfk_pkg::TR_BITS-1:0] trans(
      input logic [ptfk_pkg::OFS_BITS-1:0] v, input logic signed [TW-1:0] a,
      input logic [ptfk_pkg::OFS_BITS-1:0] h, input logic signed [TW-1:0] b);
    wide_t s;
    s = -(wide_t'(v) * wide_t'(a)) - wide_t'(h) * wide_t'(b);
    s = (s + (wide_t'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (s > ptfk_pkg::TR_LIMIT) s = ptfk_pkg::TR_LIMIT;
    else if (s < -ptfk_pkg::TR_LIMIT) s = -ptfk_pkg::TR_LIMIT;
    return s[ptfk_pkg::TR_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= sp;
      r[1] <= mul_trig(cp, st);
      r[2] <= mul_trig(cp, ct);
      r[3] <= -cp;
      r[4] <= mul_trig(sp, st);
      r[5] <= mul_trig(sp, ct);
      r[6] <= -ct;
      r[7] <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) m[k] <= r[k];
      t[0] <= trans(vo, r[1], hz, r[0]);
      t[1] <= trans(vo, r[4], hz, r[3]);
      t[2] <= trans(vo, r[6], '0, '0);
    end
  end
endmodule
`default_nettype wire

/* sv/pan_tilt_forward_kinematics.sv */
// Registered path: CORDIC input, CORDIC stages, CORDIC output, products, result.
// Throughput: one word per cycle; the whole pipeline advances when the
// output register is empty or being taken, and stalls as one otherwise.
// Reset: synchronous, active high; clears valid bits, offsets take 5014 and 4456.
`timescale 1ns / 1ps
`default_nettype none
`include "pan_tilt_forward_kinematics_assert.svh"
module pan_tilt_forward_kinematics #(
  parameter int ANGLE_BITS     = ptfk_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = ptfk_pkg::TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = ptfk_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [ptfk_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [ptfk_pkg::OFS_BITS-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [ANGLE_BITS-1:0] pan_angle,
  input  wire logic signed [ANGLE_BITS-1:0] tilt_angle,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [TRIG_FRAC_BITS+1:0] m00, output logic signed [TRIG_FRAC_BITS+1:0] m01,
  output logic signed [TRIG_FRAC_BITS+1:0] m02, output logic signed [TRIG_FRAC_BITS+1:0] m10,
  output logic signed [TRIG_FRAC_BITS+1:0] m11, output logic signed [TRIG_FRAC_BITS+1:0] m12,
  output logic signed [TRIG_FRAC_BITS+1:0] m21, output logic signed [TRIG_FRAC_BITS+1:0] m22,
  output logic signed [18:0] tx, output logic signed [18:0] ty,
  output logic signed [18:0] tz
);
  localparam int NS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int LAT = NS + 4;
  localparam int TW  = TRIG_FRAC_BITS + 2;

  logic [ptfk_pkg::OFS_BITS-1:0] hz, vo;
  always_ff @(posedge clk) begin
    if (rst) begin
      hz <= ptfk_pkg::HZ_RESET;
      vo <= ptfk_pkg::V_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptfk_pkg::REG_HORIZONTAL: hz <= cfg_data;
        ptfk_pkg::REG_VERTICAL:   vo <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  logic signed [TW-1:0] sp, cp, st, ct;
  ptfk_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)) u_pan (
    .clk(clk), .en(en), .angle(pan_angle), .sin_o(sp), .cos_o(cp));
  ptfk_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)) u_tilt (
    .clk(clk), .en(en), .angle(tilt_angle), .sin_o(st), .cos_o(ct));

  logic signed [TW-1:0] m [8];
  logic signed [18:0] t [3];
  ptfk_merge #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .sp(sp), .cp(cp), .st(st), .ct(ct),
    .hz(hz), .vo(vo), .m(m), .t(t));

  assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
  assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
  assign m21 = m[6]; assign m22 = m[7];
  assign tx = t[0]; assign ty = t[1]; assign tz = t[2];

  `PTFK_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(tz))
  `PTFK_ASSERT_IMP(a_ready_free, clk, rst, !out_valid, in_ready)
  `PTFK_ASSERT_IMP(a_trig_range, clk, rst, out_valid,
    (m22 <= 16'sd16384) && (m22 >= -16'sd16384) && (m00 <= 16'sd16384) && (m00 >= -16'sd16384))
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for pan_tilt_forward_kinematics: directed and random angle
// pairs under several idle/stall phases and offset settings, checked against a local predictor.
// Depends on ptfk_pkg, ptfk_if and the RTL top level.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [15:0] pan;
  logic signed [15:0] tilt;
} angle_pair_t;

typedef struct packed {
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m21, m22;
  logic signed [18:0] tx, ty, tz;
} pose_t;

class pose_scoreboard;
  longint hz;
  longint vo;
  pose_t pending[$];
  int errors;

  function new();
    hz = longint'(ptfk_pkg::HZ_RESET);
    vo = longint'(ptfk_pkg::V_RESET);
    errors = 0;
  endfunction

  function longint clamp(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function void sin_cos(logic signed [15:0] ang, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = longint'(ang) * (longint'(1) << 17);
    x = longint'(ptfk_pkg::GAIN_Q30);
    y = 0;
    flip = 0;
    if (a > longint'(ptfk_pkg::HALF_PI_Q30)) begin
      a -= longint'(ptfk_pkg::PI_Q30);
      flip = 1;
    end else if (a < -longint'(ptfk_pkg::HALF_PI_Q30)) begin
      a += longint'(ptfk_pkg::PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(ptfk_pkg::atan_q30(i));
      end else begin
        x += dx; y -= dy; a += longint'(ptfk_pkg::atan_q30(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = clamp((y + (1 << 15)) >>> 16, 16384);
    c = clamp((x + (1 << 15)) >>> 16, 16384);
  endfunction

  function longint prod(longint a, longint b);
    return clamp((a * b + 8192) >>> 14, 16384);
  endfunction

  function longint offset_sum(longint a, longint b);
    return clamp((-vo * a - hz * b + 8192) >>> 14, 131072);
  endfunction

  function void note_angles(angle_pair_t w);
    longint sp, cp, st, ct;
    pose_t p;
    sin_cos(w.pan, sp, cp);
    sin_cos(w.tilt, st, ct);
    p.m00 = 16'(sp);
    p.m01 = 16'(prod(cp, st));
    p.m02 = 16'(prod(cp, ct));
    p.m10 = 16'(-cp);
    p.m11 = 16'(prod(sp, st));
    p.m12 = 16'(prod(sp, ct));
    p.m21 = 16'(-ct);
    p.m22 = 16'(st);
    p.tx = 19'(offset_sum(p.m01, p.m00));
    p.ty = 19'(offset_sum(p.m11, p.m10));
    p.tz = 19'(clamp((-vo * longint'(p.m21) + 8192) >>> 14, 131072));
    pending.push_back(p);
  endfunction

  function void check_pose(pose_t got);
    pose_t e;
    logic signed [18:0] ev[11], gv[11];
    string names[11] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m21", "m22",
                         "tx", "ty", "tz"};
    if (pending.size() == 0) begin
      $error("unexpected result word");
      errors++;
      return;
    end
    e = pending.pop_front();
    ev = '{e.m00, e.m01, e.m02, e.m10, e.m11, e.m12, e.m21, e.m22, e.tx, e.ty, e.tz};
    gv = '{got.m00, got.m01, got.m02, got.m10, got.m11, got.m12, got.m21, got.m22,
           got.tx, got.ty, got.tz};
    for (int k = 0; k < 11; k++)
      if (ev[k] !== gv[k]) begin
        $error("%s: expected %0d, got %0d", names[k], ev[k], gv[k]);
        errors++;
      end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ptfk_pkg::CFG_IDX_BITS-1:0] cfg_index = ptfk_pkg::REG_HORIZONTAL;
  logic [15:0] cfg_data = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  pose_scoreboard sb = new();

  ptfk_if #(.payload_t(angle_pair_t)) in_ch ();
  ptfk_if #(.payload_t(pose_t)) out_ch ();

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pan_tilt_forward_kinematics u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .pan_angle(in_ch.data.pan), .tilt_angle(in_ch.data.tilt),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .m00(out_ch.data.m00), .m01(out_ch.data.m01), .m02(out_ch.data.m02),
    .m10(out_ch.data.m10), .m11(out_ch.data.m11), .m12(out_ch.data.m12),
    .m21(out_ch.data.m21), .m22(out_ch.data.m22),
    .tx(out_ch.data.tx), .ty(out_ch.data.ty), .tz(out_ch.data.tz)
  );

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_angles(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_pose(out_ch.data);
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_angles(logic signed [15:0] p, logic signed [15:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data = '{pan: p, tilt: t};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_offset(logic [ptfk_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == ptfk_pkg::REG_HORIZONTAL) sb.hz = longint'(val);
    else sb.vo = longint'(val);
  endtask

  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] edges[10] = '{0, 32767, -32768, 12867, 12868, -12867, -12868,
                                       25736, -25736, 1};
    case ($urandom_range(3))
      0: return edges[$urandom_range(9)] + $signed(16'($urandom_range(6))) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] dir[10] = '{0, 32767, -32768, 12867, 12868, -12867, -12868,
                                     25736, -25736, 8192};
    int hz_set[4] = '{65535, 0, 5014, 0};
    int vo_set[4] = '{65535, 0, 4456, 0};
    repeat (2) @(negedge clk);
    rst = 0;
    for (int i = 0; i < 10; i++) send_angles(dir[i], dir[(i * 3 + 1) % 10]);
    for (int i = 0; i < 10; i++) send_angles(dir[i], dir[i]);
    for (int ph = 0; ph < 4; ph++) begin
      hz_set[3] = $urandom_range(65535);
      vo_set[3] = $urandom_range(65535);
      write_offset(ptfk_pkg::REG_HORIZONTAL, 16'(hz_set[ph]));
      write_offset(ptfk_pkg::REG_VERTICAL, 16'(vo_set[ph]));
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 75; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 75; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int n = 0; n < 345; n++) send_angles(pick_angle(), pick_angle());
    end
    drain();
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end
endmodule
